// ===== hw/rtl/opl_write_note_event_extractor_core_macros.svh =====
// Assertion macros shared by the note event extractor RTL.
`ifndef OPL_WRITE_NOTE_EVENT_EXTRACTOR_CORE_MACROS_SVH
`define OPL_WRITE_NOTE_EVENT_EXTRACTOR_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ONEE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ONEE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/onee_pkg.sv =====
// Package: shared types, constants and tables for the note event extractor.
package onee_pkg;
  localparam int PatchSlots = 128;
  localparam int PatchIdxW  = 7;
  localparam int NoteBits   = 16;
  localparam int TimeBits   = 32;
  localparam int NChan      = 9;

  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_END   = 2'd1,
    EV_SONG  = 2'd2
  } ev_kind_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_KEY,
    ST_FSCAN,
    ST_FRD,
    ST_PGATH,
    ST_PSRCH,
    ST_PCMP,
    ST_PADD,
    ST_PITCH,
    ST_FOUT,
    ST_ESCAN,
    ST_SONG,
    ST_CLEAR,
    ST_WAIT
  } state_t;

  typedef enum logic [1:0] {
    RET_NONE,
    RET_WRITE_FILL,
    RET_END_SCAN,
    RET_SONG
  } ret_t;

  // Pitch unit control
  typedef struct packed {
    logic       start;
    logic [2:0] block;
    logic [9:0] fnum;
  } pitch_req_t;

  typedef struct packed {
    logic       done;
    logic [6:0] note;
  } pitch_rsp_t;

  // Operator slot offset for each melodic channel
  function automatic logic [4:0] op_slot(input logic [3:0] ch);
    logic [4:0] s;
    unique case (ch)
      4'd0: s = 5'd0;
      4'd1: s = 5'd1;
      4'd2: s = 5'd2;
      4'd3: s = 5'd8;
      4'd4: s = 5'd9;
      4'd5: s = 5'd10;
      4'd6: s = 5'd16;
      4'd7: s = 5'd17;
      4'd8: s = 5'd18;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // 2^((2r-1)/24) scaled by 1e9
  function automatic logic [30:0] quarter_ratio(input logic [3:0] r);
    logic [30:0] q;
    unique case (r)
      4'd0:  q = 31'd971531941;
      4'd1:  q = 31'd1029302237;
      4'd2:  q = 31'd1090507733;
      4'd3:  q = 31'd1155352697;
      4'd4:  q = 31'd1224053543;
      4'd5:  q = 31'd1296839555;
      4'd6:  q = 31'd1373953647;
      4'd7:  q = 31'd1455653183;
      4'd8:  q = 31'd1542210825;
      4'd9:  q = 31'd1633915453;
      4'd10: q = 31'd1731073122;
      4'd11: q = 31'd1834008086;
      default: q = 31'd0;
    endcase
    return q;
  endfunction
endpackage

// ===== hw/rtl/opl_write_note_event_extractor_core.sv =====
// Top level: OPL register-write note event extractor.
// Usage:
//  Input channel (in_valid/in_stall) takes one record: kind, reg_addr,
//  reg_value, delay_ticks. kind 1 marks the end of the song.
//  Result channel (out_valid/out_stall) gives note starts, note ends and
//  the song end, with out_last on the final beat caused by a record.
//  One record is worked at a time; in_stall is high while it is worked.
//  A plain write passes through the key and wait states. Each note start
//  filled in costs a walk over the shadow registers (13 reads), a search
//  of the patch table (up to 128 stored patches) and the pitch unit.
//  An end record also runs a clearing pass over all 256 entries of the
//  register shadow; no record is taken meanwhile. After reset the same
//  clearing pass runs first.
//  When the receiver stalls, the held beat stays and work waits.
module opl_write_note_event_extractor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_reg_addr,
  input  logic [7:0]  in_reg_value,
  input  logic [15:0] in_delay_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [3:0]  out_channel,
  output logic [15:0] out_note_number,
  output logic [31:0] out_event_time,
  output logic [6:0]  out_patch_index,
  output logic [2:0]  out_octave_block,
  output logic [9:0]  out_freq_number,
  output logic [6:0]  out_xm_note,
  output logic [5:0]  out_carrier_level,
  output logic        out_table_full,
  output logic        out_last
);
  import onee_pkg::*;
  `include "opl_write_note_event_extractor_core_macros.svh"

  state_t st_r, st_nxt;
  ret_t   ret_r;

  // register shadow memory
  logic [7:0] shadow_mem [256];
  logic       sh_we;
  logic [7:0] sh_wa, sh_ra, sh_wd, sh_rd_r;

  // patch table memories
  logic [63:0] plo_mem [PatchSlots];
  logic [23:0] phi_mem [PatchSlots];
  logic        p_we;
  logic [PatchIdxW-1:0] p_wa, p_ra;
  logic [63:0] plo_rd_r;
  logic [23:0] phi_rd_r;
  logic [8:0]  pcount_r;

  logic [TimeBits-1:0] time_r;
  logic [NoteBits-1:0] ncnt_r;
  logic [8:0] snd_r, pend_r;
  logic [NoteBits-1:0] snote_r [NChan];
  logic [NoteBits-1:0] pnote_r [NChan];

  // working registers
  logic [7:0]  addr_r, val_r;
  logic [15:0] delay_r;
  logic [3:0]  ch_r;
  logic [3:0]  step_r;
  logic [8:0]  idx_r;
  logic [8:0]  clr_r;
  logic [63:0] wlo_r;
  logic [23:0] whi_r;
  logic [7:0]  b0_r, a0_r, c43_r;
  logic [6:0]  pidx_r;
  logic        full_r;

  // output register
  logic        ov_r;
  logic [1:0]  ok_r;
  logic [3:0]  och_r;
  logic [15:0] onote_r;
  logic [31:0] otime_r;
  logic [6:0]  opat_r, oxm_r;
  logic [2:0]  oblk_r;
  logic [9:0]  ofn_r;
  logic [5:0]  olvl_r;
  logic        ofull_r, olast_r;

  pitch_req_t preq;
  pitch_rsp_t prsp;

  onee_pitch u_pitch (.clk(clk), .rst_n(rst_n), .req(preq), .rsp(prsp));

  logic in_acc, out_free;
  assign out_free = !ov_r || !out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE);

  // next pending channel at or after ch_r
  logic [3:0] pend_ch;
  logic       pend_any;
  logic [3:0] snd_ch;
  logic       snd_any;
  always_comb begin
    pend_ch = 4'd0; pend_any = 1'b0;
    snd_ch  = 4'd0; snd_any  = 1'b0;
    for (int i = NChan - 1; i >= 0; i--) begin
      if (pend_r[i] && 4'(i) >= ch_r) begin pend_ch = 4'(i); pend_any = 1'b1; end
      if (snd_r[i] && 4'(i) >= ch_r) begin snd_ch = 4'(i); snd_any = 1'b1; end
    end
  end

  // shadow read address for gather step
  logic [4:0] slot;
  logic [7:0] gaddr;
  assign slot = op_slot(ch_r);
  always_comb begin
    unique case (step_r)
      4'd0:  gaddr = 8'h20 + {3'd0, slot};
      4'd1:  gaddr = 8'h40 + {3'd0, slot};
      4'd2:  gaddr = 8'h60 + {3'd0, slot};
      4'd3:  gaddr = 8'h80 + {3'd0, slot};
      4'd4:  gaddr = 8'hE0 + {3'd0, slot};
      4'd5:  gaddr = 8'h23 + {3'd0, slot};
      4'd6:  gaddr = 8'h43 + {3'd0, slot};
      4'd7:  gaddr = 8'h63 + {3'd0, slot};
      4'd8:  gaddr = 8'h83 + {3'd0, slot};
      4'd9:  gaddr = 8'hE3 + {3'd0, slot};
      4'd10: gaddr = 8'hC0 + {4'd0, ch_r};
      4'd11: gaddr = 8'hA0 + {4'd0, ch_r};
      default: gaddr = 8'hB0 + {4'd0, ch_r};
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: if (clr_r == 9'd255) st_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) st_nxt = in_kind ? ST_FSCAN : ST_KEY;
      ST_KEY:   if (out_free) st_nxt = ST_WAIT;
      ST_WAIT:  st_nxt = (delay_r != 16'd0) ? ST_FSCAN : ST_IDLE;
      ST_FSCAN: begin
        if (pend_any) st_nxt = ST_FRD;
        else if (ret_r == RET_END_SCAN) st_nxt = ST_ESCAN;
        else st_nxt = ST_IDLE;
      end
      ST_FRD:   if (step_r == 4'd12) st_nxt = ST_PGATH;
      ST_PGATH: st_nxt = ST_PSRCH;
      ST_PSRCH: st_nxt = (idx_r == pcount_r || idx_r == 9'(PatchSlots)) ? ST_PADD : ST_PCMP;
      ST_PCMP:  st_nxt = (plo_rd_r == wlo_r && phi_rd_r == whi_r) ? ST_PITCH : ST_PSRCH;
      ST_PADD:  st_nxt = ST_PITCH;
      ST_PITCH: if (prsp.done) st_nxt = ST_FOUT;
      ST_FOUT:  if (out_free) st_nxt = ST_FSCAN;
      ST_ESCAN: if (out_free && !snd_any) st_nxt = ST_SONG;
      ST_SONG:  if (out_free) st_nxt = ST_CLEAR;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (sh_we) shadow_mem[sh_wa] <= sh_wd;
    sh_rd_r <= shadow_mem[sh_ra];
    if (p_we) begin
      plo_mem[p_wa] <= wlo_r;
      phi_mem[p_wa] <= whi_r;
    end
    plo_rd_r <= plo_mem[p_ra];
    phi_rd_r <= phi_mem[p_ra];
  end

  // key state is read from the record's own register while it waits
  always_comb begin
    sh_we = 1'b0; sh_wa = addr_r; sh_wd = val_r;
    sh_ra = in_reg_addr;
    p_we  = (st_r == ST_PADD) && (pcount_r < 9'(PatchSlots));
    p_wa  = pcount_r[PatchIdxW-1:0];
    p_ra  = idx_r[PatchIdxW-1:0];
    if (st_r == ST_CLEAR) begin sh_we = 1'b1; sh_wa = clr_r[7:0]; sh_wd = 8'd0; end
    else if (st_r == ST_KEY && out_free) sh_we = 1'b1;
    if (st_r == ST_FRD || st_r == ST_FSCAN) sh_ra = gaddr;
    else if (st_r == ST_KEY) sh_ra = addr_r;
  end

  logic key_reg;
  assign key_reg = (addr_r >= 8'hB0) && (addr_r <= 8'hB8);
  logic [3:0] kch;
  assign kch = 4'(addr_r - 8'hB0);

  // a new beat is loaded into the output register this cycle
  logic ov_load;
  assign ov_load = out_free && ((st_r == ST_KEY && key_reg && !val_r[5] && sh_rd_r[5] &&
                   snd_r[kch]) || st_r == ST_FOUT || (st_r == ST_ESCAN && snd_any) ||
                   st_r == ST_SONG);

  logic [TimeBits:0] tsum;
  assign tsum = {1'b0, time_r} + {{(TimeBits-15){1'b0}}, delay_r};

  always_comb preq = '{start: (st_r == ST_PADD) || (st_r == ST_PCMP &&
                        plo_rd_r == wlo_r && phi_rd_r == whi_r),
                      block: b0_r[4:2], fnum: {b0_r[1:0], a0_r}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; clr_r <= 9'd0; ret_r <= RET_NONE;
      time_r <= '0; ncnt_r <= '0; snd_r <= '0; pend_r <= '0;
      pcount_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && !out_stall && !ov_load) ov_r <= 1'b0;
      unique case (st_r)
        ST_CLEAR: clr_r <= clr_r + 9'd1;
        ST_IDLE: if (in_acc) begin
          addr_r <= in_reg_addr; val_r <= in_reg_value; delay_r <= in_delay_ticks;
          ch_r <= 4'd0;
          ret_r <= in_kind ? RET_END_SCAN : RET_WRITE_FILL;
        end
        ST_KEY: begin
          if (out_free) begin
            if (key_reg && val_r[5] && !sh_rd_r[5]) begin
              pnote_r[kch] <= ncnt_r; snote_r[kch] <= ncnt_r;
              pend_r[kch] <= 1'b1; snd_r[kch] <= 1'b1; ncnt_r <= ncnt_r + NoteBits'(1);
            end else if (key_reg && !val_r[5] && sh_rd_r[5] && snd_r[kch]) begin
              snd_r[kch] <= 1'b0;
              ov_r <= 1'b1; ok_r <= EV_END; och_r <= kch; onote_r <= snote_r[kch];
              otime_r <= time_r; opat_r <= '0; oblk_r <= '0; ofn_r <= '0;
              oxm_r <= '0; olvl_r <= '0; ofull_r <= 1'b0;
              olast_r <= (delay_r == 16'd0) || !(|(pend_r));
            end
          end
        end
        ST_WAIT: begin
          ch_r <= 4'd0;
          if (delay_r == 16'd0) ret_r <= RET_NONE;
        end
        ST_FSCAN: begin
          step_r <= 4'd0;
          if (pend_any) ch_r <= pend_ch;
          else if (ret_r == RET_WRITE_FILL) begin
            pend_r <= '0;
            time_r <= tsum[TimeBits] ? '1 : tsum[TimeBits-1:0];
          end else if (ret_r == RET_END_SCAN) begin
            pend_r <= '0; ch_r <= 4'd0;
          end
        end
        ST_FRD: begin
          // read data is registered, so it belongs to the previous step
          step_r <= step_r + 4'd1;
          if (step_r != 4'd0) begin
            unique case (step_r - 4'd1)
              4'd0: wlo_r[7:0]   <= sh_rd_r;
              4'd1: wlo_r[15:8]  <= sh_rd_r;
              4'd2: wlo_r[23:16] <= sh_rd_r;
              4'd3: wlo_r[31:24] <= sh_rd_r;
              4'd4: wlo_r[39:32] <= sh_rd_r;
              4'd5: wlo_r[47:40] <= sh_rd_r;
              4'd6: begin wlo_r[55:48] <= sh_rd_r & 8'hC0; c43_r <= sh_rd_r; end
              4'd7: wlo_r[63:56] <= sh_rd_r;
              4'd8: whi_r[7:0]   <= sh_rd_r;
              4'd9: whi_r[15:8]  <= sh_rd_r;
              4'd10: whi_r[23:16] <= sh_rd_r & 8'h0F;
              default: a0_r <= sh_rd_r;
            endcase
          end
        end
        ST_PGATH: begin b0_r <= sh_rd_r; idx_r <= 9'd0; end
        ST_PSRCH: ;
        ST_PCMP: begin
          if (plo_rd_r == wlo_r && phi_rd_r == whi_r) begin
            pidx_r <= idx_r[PatchIdxW-1:0]; full_r <= 1'b0;
          end
          idx_r <= idx_r + 9'd1;
        end
        ST_PADD: begin
          if (pcount_r < 9'(PatchSlots)) begin
            pidx_r <= pcount_r[PatchIdxW-1:0]; full_r <= 1'b0;
            pcount_r <= pcount_r + 9'd1;
          end else begin
            pidx_r <= '0; full_r <= 1'b1;
          end
        end
        ST_PITCH: ;
        ST_FOUT: if (out_free) begin
          pend_r[ch_r] <= 1'b0;
          ov_r <= 1'b1; ok_r <= EV_START; och_r <= ch_r; onote_r <= pnote_r[ch_r];
          otime_r <= time_r; opat_r <= pidx_r; oblk_r <= b0_r[4:2];
          ofn_r <= {b0_r[1:0], a0_r}; oxm_r <= prsp.note; olvl_r <= c43_r[5:0];
          ofull_r <= full_r;
          olast_r <= (ret_r == RET_WRITE_FILL) && !(|(pend_r & ~(9'd1 << ch_r)));
          ch_r <= ch_r + 4'd1;
        end
        ST_ESCAN: if (out_free && snd_any) begin
          ov_r <= 1'b1; ok_r <= EV_END; och_r <= snd_ch; onote_r <= snote_r[snd_ch];
          otime_r <= time_r; opat_r <= '0; oblk_r <= '0; ofn_r <= '0;
          oxm_r <= '0; olvl_r <= '0; ofull_r <= 1'b0; olast_r <= 1'b0;
          ch_r <= snd_ch + 4'd1;
        end
        ST_SONG: if (out_free) begin
          ov_r <= 1'b1; ok_r <= EV_SONG; och_r <= '0; onote_r <= '0;
          otime_r <= time_r; opat_r <= '0; oblk_r <= '0; ofn_r <= '0;
          oxm_r <= '0; olvl_r <= '0; ofull_r <= 1'b0; olast_r <= 1'b1;
          time_r <= '0; ncnt_r <= '0; snd_r <= '0; pend_r <= '0;
          pcount_r <= '0; clr_r <= 9'd0; ret_r <= RET_NONE;
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = ov_r;
  assign out_event_kind    = ok_r;
  assign out_channel       = och_r;
  assign out_note_number   = onote_r;
  assign out_event_time    = otime_r;
  assign out_patch_index   = opat_r;
  assign out_octave_block  = oblk_r;
  assign out_freq_number   = ofn_r;
  assign out_xm_note       = oxm_r;
  assign out_carrier_level = olvl_r;
  assign out_table_full    = ofull_r;
  assign out_last          = olast_r;

  `ONEE_ASSERT_IMP(a_busy_stall, st_r != ST_IDLE, in_stall, "record taken while busy")
  `ONEE_ASSERT_IMP(a_pcount_max, 1'b1, pcount_r <= 9'(PatchSlots), "patch count overflow")
  `ONEE_ASSERT_NXT(a_song_clear, st_r == ST_SONG && out_free, snd_r == '0 && pend_r == '0, "state not cleared at song end")
endmodule

// ===== hw/rtl/onee_pitch.sv =====
// Iterative pitch unit: counts note thresholds reached, one per cycle.
module onee_pitch (
  input  logic                 clk,
  input  logic                 rst_n,
  input  onee_pkg::pitch_req_t req,
  output onee_pkg::pitch_rsp_t rsp
);
  import onee_pkg::*;
  `include "opl_write_note_event_extractor_core_macros.svh"

  // lhs = fnum*49716*2^block*1e9 ; thr = 440*Q*2^(e/12+15)
  // Both sides divided by 1e9*... are not integral, so compare scaled:
  // fnum*49716*1e9 << block vs 440*Q << sh. Split: a = fnum*49716 (26 bits),
  // b = 440*Q (40 bits). Compare a*1e9 << block with b << sh, done as
  // a*1e9 computed once in the first phase (reused constant), then shifts only.
  // e = n+2 is tracked as remainder and quotient by 12, stepped per note.
  logic        busy_r, busy_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [6:0]  n_r, n_nxt;
  logic [6:0]  note_r, note_nxt;
  logic [25:0] a_r, a_nxt;
  logic [55:0] lhs_r, lhs_nxt;
  logic [2:0]  blk_r, blk_nxt;
  logic        fz_r, fz_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  er_r, er_nxt;
  logic [3:0]  eq_r, eq_nxt;
  logic [39:0] thr_base;
  logic [63:0] thr;
  logic [63:0] lhs_full;

  // threshold for note n_r, e = n+2
  always_comb begin
    thr_base = 40'(440) * {9'd0, quarter_ratio(er_r)};
    thr      = {24'd0, thr_base} << ({1'b0, eq_r} + 5'd15);
    lhs_full = {8'd0, lhs_r} << blk_r;
  end

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    n_nxt    = n_r;
    note_nxt = note_r;
    a_nxt    = a_r;
    lhs_nxt  = lhs_r;
    blk_nxt  = blk_r;
    fz_nxt   = fz_r;
    er_nxt   = er_r;
    eq_nxt   = eq_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      ph_nxt   = 2'd0;
      a_nxt    = 26'({16'd0, req.fnum} * 26'd49716);
      blk_nxt  = req.block;
      fz_nxt   = (req.fnum == 10'd0);
      n_nxt    = 7'd2;
      note_nxt = 7'd1;
      er_nxt   = 4'd4;
      eq_nxt   = 4'd0;
    end else if (busy_r) begin
      unique case (ph_r)
        2'd0: begin
          // a * 1e9 as 26x30 product, one multiply
          lhs_nxt = 56'({30'd0, a_r} * 56'd1000000000);
          ph_nxt  = 2'd1;
        end
        default: begin
          if (!fz_r && lhs_full >= thr) note_nxt = n_r;
          if (n_r == 7'd96) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
          n_nxt = n_r + 7'd1;
          // step e by one: wrap remainder at 12
          if (er_r == 4'd11) begin
            er_nxt = 4'd0;
            eq_nxt = eq_r + 4'd1;
          end else begin
            er_nxt = er_r + 4'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ph_r   <= ph_nxt;
    end
    n_r    <= n_nxt;
    note_r <= note_nxt;
    a_r    <= a_nxt;
    lhs_r  <= lhs_nxt;
    blk_r  <= blk_nxt;
    fz_r   <= fz_nxt;
    er_r   <= er_nxt;
    eq_r   <= eq_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.note = note_r;

  `ONEE_ASSERT_IMP(a_note_range, rsp.done, rsp.note >= 7'd1 && rsp.note <= 7'd96, "xm note out of range")
  `ONEE_ASSERT_NXT(a_done_ends, rsp.done, !busy_r || req.start, "pitch unit busy after done")
  `ONEE_ASSERT_NXT(a_start_busy, req.start, busy_r, "pitch unit did not start")
endmodule

// ===== dv/opl_note_event_checker.sv =====
// Note event checker: tracks the register stream, works out expected events, compares.
module opl_note_event_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_reg_addr,
  input  logic [7:0]  in_reg_value,
  input  logic [15:0] in_delay_ticks,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_event_kind,
  input  logic [3:0]  out_channel,
  input  logic [15:0] out_note_number,
  input  logic [31:0] out_event_time,
  input  logic [6:0]  out_patch_index,
  input  logic [2:0]  out_octave_block,
  input  logic [9:0]  out_freq_number,
  input  logic [6:0]  out_xm_note,
  input  logic [5:0]  out_carrier_level,
  input  logic        out_table_full,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_events,
  output int          event_total,
  output int          start_total,
  output int          full_total
);
  import onee_pkg::*;

  localparam logic [7:0] KeyOnBit = 8'h20;

  typedef struct packed {
    ev_kind_t    kind;
    logic [3:0]  chan;
    logic [15:0] note;
    logic [31:0] tick;
    logic [6:0]  patch;
    logic [2:0]  blk;
    logic [9:0]  fnum;
    logic [6:0]  xm;
    logic [5:0]  level;
    logic        full;
    logic        last;
  } note_event_t;

  note_event_t expected_events[$];

  // Shadow state of the song
  logic [7:0]  regs[256];
  logic [31:0] song_tick;
  logic [15:0] next_note;
  logic [8:0]  sounding;
  logic [15:0] sounding_num[9];
  logic [8:0]  awaiting_fill;
  logic [15:0] awaiting_num[9];
  logic [87:0] patch_words[PatchSlots];
  int          patch_used;

  function automatic logic [4:0] slot_of(int ch);
    logic [4:0] s;
    case (ch)
      0, 1, 2: s = 5'(ch);
      3, 4, 5: s = 5'(ch + 5);
      default: s = 5'(ch + 10);
    endcase
    return s;
  endfunction

  function automatic logic [63:0] ratio_1e9(int r);
    logic [63:0] q;
    case (r)
      0: q = 971531941;    1: q = 1029302237;  2: q = 1090507733;
      3: q = 1155352697;   4: q = 1224053543;  5: q = 1296839555;
      6: q = 1373953647;   7: q = 1455653183;  8: q = 1542210825;
      9: q = 1633915453;   10: q = 1731073122; default: q = 1834008086;
    endcase
    return q;
  endfunction

  // Equal-tempered note from block and F-number, integer thresholds only
  function automatic logic [6:0] pitch_to_xm(logic [2:0] blk, logic [9:0] fnum);
    logic [63:0] lhs, thr;
    int n, e;
    logic [6:0] res;
    res = 1;
    if (fnum == 0) return res;
    lhs = ((64'(fnum) * 64'd49716) << blk) * 64'd1000000000;
    for (n = 2; n <= 96; n++) begin
      e = n + 2;
      thr = (64'd440 * ratio_1e9(e % 12)) << (e / 12 + 15);
      if (lhs >= thr) res = 7'(n);
    end
    return res;
  endfunction

  task automatic clear_song();
    foreach (regs[i]) regs[i] = '0;
    song_tick = '0;
    next_note = '0;
    sounding = '0;
    awaiting_fill = '0;
    patch_used = 0;
    foreach (sounding_num[i]) begin
      sounding_num[i] = '0;
      awaiting_num[i] = '0;
    end
  endtask

  function automatic note_event_t make_end(int ch, logic [15:0] num, ev_kind_t k);
    note_event_t e;
    e = '0;
    e.kind = k;
    e.chan = 4'(ch);
    e.note = num;
    e.tick = song_tick;
    return e;
  endfunction

  // Fill in every note started since the last nonzero delay
  task automatic fill_awaiting(inout note_event_t evs[$]);
    note_event_t e;
    logic [4:0] m;
    logic [87:0] word;
    int idx;
    for (int ch = 0; ch < 9; ch++) begin
      if (awaiting_fill[ch]) begin
        m = slot_of(ch);
        word = {regs[8'hC0 + ch] & 8'h0F, regs[8'hE3 + m], regs[8'h83 + m],
                regs[8'h63 + m], regs[8'h43 + m] & 8'hC0, regs[8'h23 + m],
                regs[8'hE0 + m], regs[8'h80 + m], regs[8'h60 + m],
                regs[8'h40 + m], regs[8'h20 + m]};
        e = '0;
        e.kind = EV_START;
        e.chan = 4'(ch);
        e.note = awaiting_num[ch];
        e.tick = song_tick;
        idx = -1;
        for (int i = 0; i < patch_used; i++)
          if (idx < 0 && patch_words[i] == word) idx = i;
        if (idx < 0 && patch_used >= PatchSlots) begin
          e.full = 1'b1;
          idx = 0;
        end else if (idx < 0) begin
          patch_words[patch_used] = word;
          idx = patch_used++;
        end
        e.patch = 7'(idx);
        e.blk = regs[8'hB0 + ch][4:2];
        e.fnum = {regs[8'hB0 + ch][1:0], regs[8'hA0 + ch]};
        e.xm = pitch_to_xm(e.blk, e.fnum);
        e.level = regs[8'h43 + m][5:0];
        evs.push_back(e);
      end
    end
    awaiting_fill = '0;
  endtask

  task automatic predict_record(logic kind, logic [7:0] ra, logic [7:0] rv,
                                logic [15:0] dly);
    note_event_t evs[$];
    logic [32:0] sum;
    int ch;
    logic was_on, on;
    if (kind) begin
      fill_awaiting(evs);
      for (ch = 0; ch < 9; ch++)
        if (sounding[ch]) evs.push_back(make_end(ch, sounding_num[ch], EV_END));
      evs.push_back(make_end(0, '0, EV_SONG));
      clear_song();
    end else begin
      was_on = (ra >= 8'hB0 && ra <= 8'hB8) && (regs[ra] & KeyOnBit) != 0;
      regs[ra] = rv;
      if (ra >= 8'hB0 && ra <= 8'hB8) begin
        ch = ra - 8'hB0;
        on = (rv & KeyOnBit) != 0;
        if (on && !was_on) begin
          awaiting_num[ch] = next_note;
          sounding_num[ch] = next_note;
          awaiting_fill[ch] = 1'b1;
          sounding[ch] = 1'b1;
          next_note++;
        end else if (!on && was_on && sounding[ch]) begin
          evs.push_back(make_end(ch, sounding_num[ch], EV_END));
          sounding[ch] = 1'b0;
        end
      end
      if (dly != 0) fill_awaiting(evs);
      sum = {1'b0, song_tick} + 33'(dly);
      song_tick = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) expected_events.push_back(evs[i]);
  endtask

  note_event_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_song();
      expected_events.delete();
      fail_count <= 0;
      event_total <= 0;
      start_total <= 0;
      full_total <= 0;
    end else begin
      if (in_valid && !in_stall)
        predict_record(in_kind, in_reg_addr, in_reg_value, in_delay_ticks);
      if (out_valid && !out_stall) begin
        got = {ev_kind_t'(out_event_kind), out_channel, out_note_number,
               out_event_time, out_patch_index, out_octave_block, out_freq_number,
               out_xm_note, out_carrier_level, out_table_full, out_last};
        event_total <= event_total + 1;
        if (out_event_kind == EV_START) start_total <= start_total + 1;
        if (out_table_full) full_total <= full_total + 1;
        if (expected_events.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: unexpected event beat %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("ERROR: event mismatch\n  exp kind %0d ch %0d note %0d t %0d pat %0d blk %0d fnum %0d xm %0d lvl %0d full %0b last %0b\n  got kind %0d ch %0d note %0d t %0d pat %0d blk %0d fnum %0d xm %0d lvl %0d full %0b last %0b",
                want.kind, want.chan, want.note, want.tick, want.patch, want.blk,
                want.fnum, want.xm, want.level, want.full, want.last,
                got.kind, got.chan, got.note, got.tick, got.patch, got.blk,
                got.fnum, got.xm, got.level, got.full, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_events <= expected_events.size();
  end
endmodule

// ===== dv/tb_opl_write_note_event_extractor_core.sv =====
// Testbench top: drives register-write records and end items, gives the verdict.
module tb_opl_write_note_event_extractor_core;
  import onee_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [7:0]  in_reg_addr = '0;
  logic [7:0]  in_reg_value = '0;
  logic [15:0] in_delay_ticks = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_kind;
  logic [3:0]  out_channel;
  logic [15:0] out_note_number;
  logic [31:0] out_event_time;
  logic [6:0]  out_patch_index;
  logic [2:0]  out_octave_block;
  logic [9:0]  out_freq_number;
  logic [6:0]  out_xm_note;
  logic [5:0]  out_carrier_level;
  logic        out_table_full;
  logic        out_last;

  int fail_count, pending_events, event_total, start_total, full_total;
  bit calm_phase = 0;
  bit hold_receiver = 0;
  int records_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  opl_write_note_event_extractor_core u_dut (.*);

  opl_note_event_checker u_check (.*);

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        out_stall <= 1'b1;
        for (n = 0; n < 3000; n++) @(posedge clk);
        out_stall <= 1'b0;
        hold_receiver = 0;
      end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one record and hold it until the block takes it; valid drops only on idling
  task automatic send_record(logic kind, logic [7:0] ra, logic [7:0] rv,
                             logic [15:0] dly);
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_reg_addr <= ra;
    in_reg_value <= rv;
    in_delay_ticks <= dly;
    do @(posedge clk); while (in_stall);
    records_sent++;
  endtask

  task automatic drain_events();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_events != 0);
    repeat (400) @(posedge clk);
  endtask

  // Small ticks mostly, the odd extreme
  function automatic logic [15:0] pick_delay();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 16'd0;
    if (r == 9) return 16'($urandom);
    return 16'($urandom_range(1, 20));
  endfunction

  // A well-formed note: patch registers if asked, pitch registers, key-on with a picked delay
  task automatic play_note(int ch, bit vary_patch);
    logic [4:0] m;
    m = (ch < 3) ? 5'(ch) : (ch < 6) ? 5'(ch + 5) : 5'(ch + 10);
    if (vary_patch) begin
      send_record(0, 8'h20 + m, 8'($urandom), 0);
      send_record(0, 8'h43 + m, 8'($urandom), 0);
      send_record(0, 8'hC0 + ch, 8'($urandom), 0);
    end
    send_record(0, 8'hA0 + ch, 8'($urandom), 0);
    send_record(0, 8'hB0 + ch, 8'($urandom) | 8'h20, pick_delay());
  endtask

  initial begin
    int ch;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes of pitch, key-on/off, retrigger, zero F-number, large delays
    send_record(0, 8'hA0, 8'hFF, 0);
    send_record(0, 8'hB0, 8'h3F, 1);
    send_record(0, 8'hA1, 8'h00, 0);
    send_record(0, 8'hB1, 8'h20, 0);
    send_record(0, 8'hB1, 8'h00, 0);
    send_record(0, 8'hB1, 8'h20, 16'hFFFF);
    send_record(0, 8'hB8, 8'h21, 0);
    send_record(0, 8'hB8, 8'h00, 2);
    send_record(0, 8'hB0, 8'h1F, 3);
    send_record(0, 8'h43, 8'hFF, 0);
    send_record(0, 8'hB2, 8'hE0, 16'hFFFF);
    send_record(0, 8'hB2, 8'hE0, 0);
    send_record(1, 8'hFF, 8'hFF, 16'hFFFF);
    drain_events();
    // Long gaps between writes: large tick counts
    for (int i = 0; i < 8; i++) send_record(0, 8'h00, 8'h00, 16'hFFFF);
    send_record(0, 8'hB3, 8'h20, 16'hFFFF);
    send_record(1, 8'h00, 8'h00, 0);
    drain_events();

    // Patch table growth: many distinct patches on one channel
    for (int i = 0; i < 40; i++) begin
      send_record(0, 8'h20, 8'(i), 0);
      send_record(0, 8'hB0, 8'h35, 1);
      send_record(0, 8'hB0, 8'h00, 0);
    end
    hold_receiver = 1;
    for (int i = 0; i < 12; i++) play_note($urandom_range(0, 8), 0);
    send_record(1, 0, 0, 0);
    drain_events();

    // Random songs: mostly notes, some noise and key-offs
    while (records_sent < 260) begin
      if (records_sent > 225) calm_phase = 1;
      case ($urandom_range(0, 5))
        0, 1, 2: play_note($urandom_range(0, 8), $urandom_range(0, 1));
        3: begin
          ch = $urandom_range(0, 8);
          send_record(0, 8'hB0 + ch, 8'($urandom) & 8'hDF, pick_delay());
        end
        4: send_record(0, 8'($urandom), 8'($urandom), pick_delay());
        default: if ($urandom_range(0, 7) == 0) send_record(1, 8'($urandom),
                                                           8'($urandom), 16'($urandom));
      endcase
    end
    send_record(1, 0, 0, 0);
    drain_events();

    $display("Covered %0d records, %0d event beats, %0d note starts, %0d table-full starts.",
             records_sent, event_total, start_total, full_total);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
